[rtl/assert_macros.svh]
// Assertion macros used by the relaxer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RBF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define RBF_NEVER(lbl, clk, rst_n, cond) \
  `RBF_ASSERT(lbl, clk, rst_n, !(cond))

`endif

[rtl/rbf_pkg.sv]
// Types, constants and helper functions of the relaxer.
`default_nettype none

package rbf_pkg;

  localparam int unsigned MaxRooms  = 256;
  localparam int unsigned MaxBonds  = 16;
  localparam int unsigned RoomW     = 8;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned WeightW   = 10;
  localparam int unsigned AncW      = 9;
  localparam int unsigned CountW    = 9;
  localparam int unsigned TotW      = 5;
  localparam int unsigned BondAddrW = RoomW + SlotW;
  localparam int unsigned PipeAddrW = 2 * RoomW;

  localparam logic [2:0] ModeLoadRoom = 3'd0;
  localparam logic [2:0] ModeLoadBond = 3'd1;
  localparam logic [2:0] ModeLoadPipe = 3'd2;
  localparam logic [2:0] ModeRun      = 3'd3;
  localparam logic [2:0] ModeRead     = 3'd4;

  localparam logic [1:0] PipeClosed = 2'b00;
  localparam logic [1:0] PipeOpen   = 2'b01;
  localparam logic [1:0] PipeNeg    = 2'b11;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [AncW-1:0]    anc;
    logic               allowed;
    logic [TotW-1:0]    total;
  } room_rec_t;

  typedef struct packed {
    logic             we;
    logic [RoomW-1:0] waddr;
    room_rec_t        wdata;
    logic             re;
    logic [RoomW-1:0] raddr;
  } room_req_t;

  typedef struct packed {
    logic                 re;
    logic                 we;
    logic [BondAddrW-1:0] addr;
    logic [RoomW-1:0]     wdata;
  } bond_req_t;

  typedef struct packed {
    logic                 we;
    logic [PipeAddrW-1:0] waddr;
    logic [1:0]           wdata;
    logic                 re;
    logic [PipeAddrW-1:0] raddr;
  } pipe_req_t;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic [WeightW-1:0] weight;
    logic [AncW-1:0]    anc;
    logic [CountW-1:0]  rounds;
    logic               changing;
  } res_t;

  // weight plus pipe value, saturated to the 10-bit signed range
  function automatic logic [WeightW-1:0] sat_add(input logic [WeightW-1:0] a,
                                                 input logic [1:0] b);
    logic signed [WeightW:0] s;
    s = $signed({a[WeightW-1], a}) + $signed({{(WeightW-1){b[1]}}, b});
    if (s > $signed(11'sd511)) begin
      return 10'h1FF;
    end else if (s < $signed(-11'sd512)) begin
      return 10'h200;
    end
    return s[WeightW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/rbf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/rbf_seq.sv]
// Sequencer: item decode, pipe clearing pass and the relaxation run.
`default_nettype none

`include "assert_macros.svh"

module rbf_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    mode_i,
  input  wire logic [rbf_pkg::RoomW-1:0]     room_i,
  input  wire logic [rbf_pkg::SlotW-1:0]     slot_i,
  input  wire logic [rbf_pkg::RoomW-1:0]     other_room_i,
  input  wire logic [1:0]                    pipe_value_i,
  input  wire logic [rbf_pkg::WeightW-1:0]   weight_in_i,
  input  wire logic [rbf_pkg::AncW-1:0]      ancestor_in_i,
  input  wire logic                          allowed_in_i,
  input  wire logic [rbf_pkg::TotW-1:0]      bond_count_i,
  input  wire logic [rbf_pkg::CountW-1:0]    room_count_i,
  input  wire logic                          out_free_i,
  output rbf_pkg::res_t                      res_o,
  output rbf_pkg::room_req_t                 room_req_o,
  input  wire rbf_pkg::room_rec_t            room_rd_i,
  output rbf_pkg::bond_req_t                 bond_req_o,
  input  wire logic [rbf_pkg::RoomW-1:0]     bond_rd_i,
  output rbf_pkg::pipe_req_t                 pipe_req_o
  , input wire logic [1:0]                   pipe_rd_i
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_FIN   = 5'd2;
  localparam logic [4:0] S_RM_WT = 5'd3;
  localparam logic [4:0] S_B_CHK = 5'd4;
  localparam logic [4:0] S_B_WT  = 5'd5;
  localparam logic [4:0] S_B_W2  = 5'd6;
  localparam logic [4:0] S_B_W3  = 5'd7;
  localparam logic [4:0] S_D_CHK = 5'd8;
  localparam logic [4:0] S_D_BW  = 5'd9;
  localparam logic [4:0] S_D_PW  = 5'd10;
  localparam logic [4:0] S_D_FW  = 5'd11;
  localparam logic [4:0] S_D_AR  = 5'd12;
  localparam logic [4:0] S_D_AW  = 5'd13;
  localparam logic [4:0] S_D_END = 5'd14;
  localparam logic [4:0] S_NEXT  = 5'd15;
  localparam logic [4:0] S_RSEL  = 5'd16;
  localparam logic [4:0] S_RCHK  = 5'd17;

  logic [4:0]                     state_q, state_d;
  logic [rbf_pkg::PipeAddrW-1:0]  clr_q, clr_d;
  logic [2:0]                     mode_q, mode_d;
  logic [rbf_pkg::CountW-1:0]     n_q, n_d;
  logic [rbf_pkg::RoomW-1:0]      i_q, i_d, t_q, t_d, f_q, f_d;
  logic [rbf_pkg::TotW-1:0]       j_q, j_d, j2_q, j2_d, tot_i_q, tot_i_d, tot_t_q, tot_t_d;
  logic [1:0]                     p_q, p_d;
  logic [rbf_pkg::WeightW-1:0]    wi_q, wi_d, saved_q, saved_d, wsrc_q, wsrc_d;
  logic                           ai_q, ai_d;
  logic [rbf_pkg::CountW-1:0]     round_q, round_d, last_q, last_d;
  logic                           flag_q, flag_d, phase0_q, phase0_d;
  logic [rbf_pkg::WeightW-1:0]    w_new;
  logic                           accept;
  logic [rbf_pkg::CountW-1:0]     n_clamp;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (room_count_i < 9'd2) begin
      n_clamp = 9'd2;
    end else if (room_count_i > 9'(rbf_pkg::MaxRooms)) begin
      n_clamp = 9'(rbf_pkg::MaxRooms);
    end else begin
      n_clamp = room_count_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    mode_d   = mode_q;
    n_d      = n_q;
    i_d      = i_q;
    t_d      = t_q;
    f_d      = f_q;
    j_d      = j_q;
    j2_d     = j2_q;
    tot_i_d  = tot_i_q;
    tot_t_d  = tot_t_q;
    p_d      = p_q;
    wi_d     = wi_q;
    ai_d     = ai_q;
    saved_d  = saved_q;
    wsrc_d   = wsrc_q;
    round_d  = round_q;
    last_d   = last_q;
    flag_d   = flag_q;
    phase0_d = phase0_q;
    w_new    = '0;
    room_req_o = '0;
    bond_req_o = '0;
    pipe_req_o = '0;
    res_o      = '0;

    case (state_q)
      S_CLEAR: begin
        pipe_req_o.we    = 1'b1;
        pipe_req_o.waddr = clr_q;
        pipe_req_o.wdata = rbf_pkg::PipeClosed;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d  = mode_i;
          state_d = S_FIN;
          case (mode_i)
            rbf_pkg::ModeLoadRoom: begin
              room_req_o.we            = 1'b1;
              room_req_o.waddr         = room_i;
              room_req_o.wdata.weight  = weight_in_i;
              room_req_o.wdata.anc     = ancestor_in_i;
              room_req_o.wdata.allowed = allowed_in_i;
              room_req_o.wdata.total   = (bond_count_i > 5'(rbf_pkg::MaxBonds)) ?
                                         5'(rbf_pkg::MaxBonds) : bond_count_i;
            end
            rbf_pkg::ModeLoadBond: begin
              bond_req_o.we    = 1'b1;
              bond_req_o.addr  = {room_i, slot_i};
              bond_req_o.wdata = other_room_i;
            end
            rbf_pkg::ModeLoadPipe: begin
              pipe_req_o.we    = 1'b1;
              pipe_req_o.waddr = {room_i, other_room_i};
              // the unused minus-two pattern is stored as minus one
              pipe_req_o.wdata = pipe_value_i[1] ? rbf_pkg::PipeNeg : pipe_value_i;
            end
            rbf_pkg::ModeRun: begin
              flag_d     = 1'b0;
              n_d        = n_clamp;
              i_d        = '0;
              round_d    = '0;
              phase0_d   = 1'b1;
              room_req_o.re    = 1'b1;
              room_req_o.raddr = '0;
              state_d    = S_RM_WT;
            end
            rbf_pkg::ModeRead: begin
              room_req_o.re    = 1'b1;
              room_req_o.raddr = room_i;
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          res_o.valid    = 1'b1;
          res_o.done     = (mode_q inside {[rbf_pkg::ModeLoadRoom:rbf_pkg::ModeRead]});
          res_o.rounds   = last_q;
          res_o.changing = flag_q;
          if (mode_q == rbf_pkg::ModeRead) begin
            res_o.weight = room_rd_i.weight;
            res_o.anc    = room_rd_i.anc;
          end
          state_d = S_IDLE;
        end
      end
      S_RM_WT: begin
        if (!phase0_q && room_rd_i.weight == {1'b0, n_q}) begin
          state_d = S_NEXT;
        end else begin
          tot_i_d = room_rd_i.total;
          j_d     = '0;
          state_d = S_B_CHK;
        end
      end
      S_B_CHK: begin
        if (j_q < tot_i_q) begin
          bond_req_o.re   = 1'b1;
          bond_req_o.addr = {i_q, j_q[rbf_pkg::SlotW-1:0]};
          state_d = S_B_WT;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_B_WT: begin
        t_d = bond_rd_i;
        pipe_req_o.re    = 1'b1;
        pipe_req_o.raddr = {i_q, bond_rd_i};
        room_req_o.re    = 1'b1;
        room_req_o.raddr = i_q;
        state_d = S_B_W2;
      end
      S_B_W2: begin
        if (pipe_rd_i == rbf_pkg::PipeClosed) begin
          j_d     = j_q + 1'b1;
          state_d = S_B_CHK;
        end else begin
          p_d  = pipe_rd_i;
          wi_d = room_rd_i.weight;
          ai_d = room_rd_i.allowed;
          room_req_o.re    = 1'b1;
          room_req_o.raddr = t_q;
          state_d = S_B_W3;
        end
      end
      S_B_W3: begin
        w_new = rbf_pkg::sat_add(wi_q, p_q);
        if (!($signed(w_new) < $signed(room_rd_i.weight))) begin
          j_d     = j_q + 1'b1;
          state_d = S_B_CHK;
        end else if (!room_rd_i.allowed && ai_q && ({1'b0, i_q} != n_q - 1'b1) &&
                     (t_q != '0)) begin
          // detour through the target: park a trial weight, walk its reversed pipes
          saved_d = room_rd_i.weight;
          tot_t_d = room_rd_i.total;
          j2_d    = '0;
          room_req_o.we           = 1'b1;
          room_req_o.waddr        = t_q;
          room_req_o.wdata        = room_rd_i;
          room_req_o.wdata.weight = rbf_pkg::sat_add(wi_q, rbf_pkg::PipeOpen);
          state_d = S_D_CHK;
        end else begin
          room_req_o.we           = 1'b1;
          room_req_o.waddr        = t_q;
          room_req_o.wdata        = room_rd_i;
          room_req_o.wdata.weight = w_new;
          room_req_o.wdata.anc    = {1'b0, i_q};
          flag_d  = 1'b1;
          j_d     = j_q + 1'b1;
          state_d = S_B_CHK;
        end
      end
      S_D_CHK: begin
        if (j2_q < tot_t_q) begin
          bond_req_o.re   = 1'b1;
          bond_req_o.addr = {t_q, j2_q[rbf_pkg::SlotW-1:0]};
          state_d = S_D_BW;
        end else begin
          room_req_o.re    = 1'b1;
          room_req_o.raddr = t_q;
          state_d = S_D_END;
        end
      end
      S_D_BW: begin
        f_d = bond_rd_i;
        pipe_req_o.re    = 1'b1;
        pipe_req_o.raddr = {t_q, bond_rd_i};
        room_req_o.re    = 1'b1;
        room_req_o.raddr = t_q;
        state_d = S_D_PW;
      end
      S_D_PW: begin
        if (pipe_rd_i != rbf_pkg::PipeNeg) begin
          j2_d    = j2_q + 1'b1;
          state_d = S_D_CHK;
        end else begin
          wsrc_d = room_rd_i.weight;
          room_req_o.re    = 1'b1;
          room_req_o.raddr = f_q;
          state_d = S_D_FW;
        end
      end
      S_D_FW: begin
        w_new = rbf_pkg::sat_add(wsrc_q, rbf_pkg::PipeNeg);
        if ($signed(w_new) < $signed(room_rd_i.weight)) begin
          room_req_o.we           = 1'b1;
          room_req_o.waddr        = f_q;
          room_req_o.wdata        = room_rd_i;
          room_req_o.wdata.weight = w_new;
          room_req_o.wdata.anc    = {1'b0, t_q};
          flag_d  = 1'b1;
          state_d = S_D_AR;
        end else begin
          j2_d    = j2_q + 1'b1;
          state_d = S_D_CHK;
        end
      end
      S_D_AR: begin
        room_req_o.re    = 1'b1;
        room_req_o.raddr = t_q;
        state_d = S_D_AW;
      end
      S_D_AW: begin
        room_req_o.we        = 1'b1;
        room_req_o.waddr     = t_q;
        room_req_o.wdata     = room_rd_i;
        room_req_o.wdata.anc = {1'b0, i_q};
        j2_d    = j2_q + 1'b1;
        state_d = S_D_CHK;
      end
      S_D_END: begin
        room_req_o.we           = 1'b1;
        room_req_o.waddr        = t_q;
        room_req_o.wdata        = room_rd_i;
        room_req_o.wdata.weight = saved_q;
        j_d     = j_q + 1'b1;
        state_d = S_B_CHK;
      end
      S_NEXT: begin
        if (phase0_q) begin
          phase0_d = 1'b0;
          state_d  = S_RCHK;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_RSEL;
        end
      end
      S_RSEL: begin
        if ({1'b0, i_q} + 1'b1 < n_q) begin
          room_req_o.re    = 1'b1;
          room_req_o.raddr = i_q;
          state_d = S_RM_WT;
        end else begin
          round_d = round_q + 1'b1;
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (round_q < n_q && flag_q) begin
          flag_d  = 1'b0;
          i_d     = 8'd1;
          state_d = S_RSEL;
        end else begin
          last_d  = round_q;
          state_d = S_FIN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      round_q  <= '0;
      last_q   <= '0;
      flag_q   <= 1'b0;
      phase0_q <= 1'b0;
      n_q      <= 9'd2;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      round_q  <= round_d;
      last_q   <= last_d;
      flag_q   <= flag_d;
      phase0_q <= phase0_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    i_q     <= i_d;
    t_q     <= t_d;
    f_q     <= f_d;
    j_q     <= j_d;
    j2_q    <= j2_d;
    tot_i_q <= tot_i_d;
    tot_t_q <= tot_t_d;
    p_q     <= p_d;
    wi_q    <= wi_d;
    ai_q    <= ai_d;
    saved_q <= saved_d;
    wsrc_q  <= wsrc_d;
  end

  `RBF_NEVER(a_room_rw_same, clk_i, rst_ni,
             room_req_o.we && room_req_o.re && room_req_o.waddr == room_req_o.raddr)
  `RBF_ASSERT(a_clear_blocks, clk_i, rst_ni,
              (state_q == S_CLEAR) |-> (in_stall_o && !room_req_o.we && !bond_req_o.we))
  `RBF_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, accept |=> (state_q != S_IDLE))
  `RBF_ASSERT(a_round_bound, clk_i, rst_ni, (state_q == S_RCHK) |-> (round_q <= n_q))

endmodule

`default_nettype wire

[rtl/residual_bellman_ford_relaxer_unit.sv]
// Top level of the residual-graph Bellman-Ford relaxer.
`default_nettype none

// Residual-graph Bellman-Ford relaxer. Rooms (weight, ancestor, allowed flag,
// bond count), per-room bond lists and a pipe matrix of -1/0/+1 are loaded by
// items, a run item relaxes the graph, and a read item returns one room's
// weight and ancestor. Every item transfer yields exactly one result transfer,
// which also reports the round count and change flag of the last run.
// After reset the block clears the 65536-entry pipe matrix, one entry per
// cycle, and holds in_stall_o high until that pass ends; configuration
// writes are taken throughout. A new item is taken while the previous
// result still sits in the output register. A run visits room 0 and then,
// each round, the further rooms, reading each record and skipping a room
// still at the unreached weight. Each bond reads its bond entry, then the
// pipe and the room, and on a pipe that is not closed the target room; a
// detour walks the target's bonds, reading each pipe and, on a reversed
// pipe, the far room, which it writes when that pipe improves it. All of it
// is bound by the single read port of the room memory, and the result waits
// for a free output register. room_count (the single configuration
// register) is clamped to 2..256 at run start.

module residual_bellman_ford_relaxer_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rbf_pkg::CountW-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [2:0]                   mode_i,
  input  wire logic [rbf_pkg::RoomW-1:0]    room_i,
  input  wire logic [rbf_pkg::SlotW-1:0]    slot_i,
  input  wire logic [rbf_pkg::RoomW-1:0]    other_room_i,
  input  wire logic [1:0]                   pipe_value_i,
  input  wire logic [rbf_pkg::WeightW-1:0]  weight_in_i,
  input  wire logic [rbf_pkg::AncW-1:0]     ancestor_in_i,
  input  wire logic                         allowed_in_i,
  input  wire logic [rbf_pkg::TotW-1:0]     bond_count_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              done_res_o,
  output logic [rbf_pkg::WeightW-1:0]       weight_out_o,
  output logic [rbf_pkg::AncW-1:0]          ancestor_out_o,
  output logic [rbf_pkg::CountW-1:0]        rounds_used_o,
  output logic                              still_changing_o
);

  logic [rbf_pkg::CountW-1:0] room_count_q;
  logic                       out_valid_q;
  logic                       out_free;
  rbf_pkg::res_t              res;
  rbf_pkg::room_req_t         room_req;
  rbf_pkg::room_rec_t         room_rd;
  rbf_pkg::bond_req_t         bond_req;
  logic [rbf_pkg::RoomW-1:0]  bond_rd;
  rbf_pkg::pipe_req_t         pipe_req;
  logic [1:0]                 pipe_rd;

  // config register; a run samples it at its start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q <= 9'd2;
    end else if (cfg_we_i) begin
      room_count_q <= cfg_wdata_i;
    end
  end

  // output slot frees up in the same cycle its transfer completes
  assign out_free = !out_valid_q || !out_stall_i;

  rbf_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .room_i        (room_i),
    .slot_i        (slot_i),
    .other_room_i  (other_room_i),
    .pipe_value_i  (pipe_value_i),
    .weight_in_i   (weight_in_i),
    .ancestor_in_i (ancestor_in_i),
    .allowed_in_i  (allowed_in_i),
    .bond_count_i  (bond_count_i),
    .room_count_i  (room_count_q),
    .out_free_i    (out_free),
    .res_o         (res),
    .room_req_o    (room_req),
    .room_rd_i     (room_rd),
    .bond_req_o    (bond_req),
    .bond_rd_i     (bond_rd),
    .pipe_req_o    (pipe_req),
    .pipe_rd_i     (pipe_rd)
  );

  // room records: weight, ancestor, allowed, bond count
  rbf_ram #(
    .Width ($bits(rbf_pkg::room_rec_t)),
    .Depth (rbf_pkg::MaxRooms)
  ) u_room_mem (
    .clk_i   (clk_i),
    .we_i    (room_req.we),
    .waddr_i (room_req.waddr),
    .wdata_i (room_req.wdata),
    .re_i    (room_req.re),
    .raddr_i (room_req.raddr),
    .rdata_o (room_rd)
  );

  // bond lists, indexed by {room, slot}
  rbf_ram #(
    .Width (rbf_pkg::RoomW),
    .Depth (rbf_pkg::MaxRooms * rbf_pkg::MaxBonds)
  ) u_bond_mem (
    .clk_i   (clk_i),
    .we_i    (bond_req.we),
    .waddr_i (bond_req.addr),
    .wdata_i (bond_req.wdata),
    .re_i    (bond_req.re),
    .raddr_i (bond_req.addr),
    .rdata_o (bond_rd)
  );

  // pipe matrix, indexed by {source, destination}
  rbf_ram #(
    .Width (2),
    .Depth (rbf_pkg::MaxRooms * rbf_pkg::MaxRooms)
  ) u_pipe_mem (
    .clk_i   (clk_i),
    .we_i    (pipe_req.we),
    .waddr_i (pipe_req.waddr),
    .wdata_i (pipe_req.wdata),
    .re_i    (pipe_req.re),
    .raddr_i (pipe_req.raddr),
    .rdata_o (pipe_rd)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      done_res_o       <= res.done;
      weight_out_o     <= res.weight;
      ancestor_out_o   <= res.anc;
      rounds_used_o    <= res.rounds;
      still_changing_o <= res.changing;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
